>>> design/cde_pkg.sv
// Shared constants and types for the circular deque engine.
package cde_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int CAP_W  = 5;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = 5;
  localparam int ADDR_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic              clear;
    logic              push_front;
    logic              push_rear;
    logic              pop_front;
    logic              pop_rear;
    logic [DATA_W-1:0] value;
  } slot_ctrl_t;

endpackage

>>> design/cde_in_if.sv
// Command channel: valid/ready handshake with command and value.
interface cde_in_if;
  logic                                valid;
  logic                                ready;
  logic [cde_pkg::CMD_W-1:0]           command;
  logic signed [cde_pkg::DATA_W-1:0]   value;

  modport source (output valid, command, value, input ready);
  modport sink (input valid, command, value, output ready);
endinterface

>>> design/cde_out_if.sv
// Result channel: valid/ready handshake with status and end values.
interface cde_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  ok;
  logic signed [cde_pkg::DATA_W-1:0]     front_value;
  logic signed [cde_pkg::DATA_W-1:0]     rear_value;
  logic                                  is_empty;
  logic                                  is_full;
  logic [cde_pkg::OUT_CNT_W-1:0]         count;

  modport source (output valid, ok, front_value, rear_value, is_empty, is_full, count,
                  input ready);
  modport sink (input valid, ok, front_value, rear_value, is_empty, is_full, count,
                output ready);
endinterface

>>> design/cde_cell.sv
// One deque slot: holds a word and a valid bit, shifts with its neighbors.
module cde_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  cde_pkg::slot_ctrl_t            ctrl,
  input  logic [cde_pkg::DATA_W-1:0]     left_data,
  input  logic                           left_valid,
  input  logic [cde_pkg::DATA_W-1:0]     right_data,
  input  logic                           right_valid,
  output logic [cde_pkg::DATA_W-1:0]     data,
  output logic                           valid,
  output logic [cde_pkg::DATA_W-1:0]     rear_data
);

  logic [cde_pkg::DATA_W-1:0] data_next;
  logic                       valid_next;

  always_comb begin
    data_next  = data;
    valid_next = valid;
    priority if (ctrl.clear) begin
      valid_next = 1'b0;
    end else if (ctrl.push_front) begin
      data_next  = left_data;
      valid_next = left_valid;
    end else if (ctrl.push_rear) begin
      if (!valid && left_valid) begin
        data_next  = ctrl.value;
        valid_next = 1'b1;
      end
    end else if (ctrl.pop_front) begin
      data_next  = right_data;
      valid_next = right_valid;
    end else if (ctrl.pop_rear) begin
      if (valid && !right_valid) begin
        valid_next = 1'b0;
      end
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // last occupied slot drives the rear word
  assign rear_data = (valid && !right_valid) ? data : '0;

endmodule

>>> design/circular_deque_engine_core.sv
// Top level of the circular deque engine: slot chain, counter, result stage, APB.
//
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid/ready      | command, value
//  out_ch   | out | valid/ready      | ok, front_value, rear_value, is_empty, is_full, count
//  apb      | in  | psel/penable     | paddr, pwdata, prdata (capacity)
//
// One command per cycle unless stalled; each command updates the whole slot chain at once.
// The result appears the cycle after the transfer; only its ok bit is held in a register.
// A stalled result blocks new commands until it is taken.
// Reset (rst, synchronous) empties the deque and sets capacity to 16.
module circular_deque_engine_core (
  input  logic                              clk,
  input  logic                              rst,
  cde_in_if.sink                            in_ch,
  cde_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cde_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int D = cde_pkg::DEPTH;

  logic [cde_pkg::CAP_W-1:0]  capacity;
  logic [cde_pkg::CNT_W-1:0]  eff_cap;
  logic [cde_pkg::CNT_W-1:0]  cnt;
  logic [cde_pkg::CNT_W-1:0]  cnt_next;
  logic                       out_valid;
  logic                       ok;
  logic                       ok_next;
  logic                       accept;
  logic                       cap_wr;
  logic                       has_room;
  logic                       non_empty;
  logic                       empty;
  cde_pkg::slot_ctrl_t        ctrl;

  logic [cde_pkg::DATA_W-1:0] slot_data [D];
  logic                       slot_valid [D];
  logic [cde_pkg::DATA_W-1:0] slot_rear [D];
  logic [cde_pkg::DATA_W-1:0] rear_word;

  assign pready = 1'b1;
  assign prdata = 32'(capacity);
  assign cap_wr = psel && penable && pwrite && (paddr[2] == cde_pkg::REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= cde_pkg::CAP_RESET;
    end else if (cap_wr) begin
      capacity <= pwdata[cde_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    if (capacity == '0) begin
      eff_cap = cde_pkg::CNT_W'(1);
    end else if (32'(capacity) > 32'(D)) begin
      eff_cap = cde_pkg::CNT_W'(D);
    end else begin
      eff_cap = cde_pkg::CNT_W'(capacity);
    end
  end

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign has_room    = cnt < eff_cap;
  assign non_empty   = cnt != '0;

  always_comb begin
    ctrl            = '0;
    ctrl.value      = in_ch.value;
    ctrl.clear      = cap_wr;
    ok_next         = 1'b0;
    cnt_next        = cnt;
    unique case (in_ch.command)
      cde_pkg::CMD_PUSH_FRONT: begin
        ok_next         = has_room;
        ctrl.push_front = accept && has_room;
      end
      cde_pkg::CMD_PUSH_REAR: begin
        ok_next        = has_room;
        ctrl.push_rear = accept && has_room;
      end
      cde_pkg::CMD_POP_FRONT: begin
        ok_next        = non_empty;
        ctrl.pop_front = accept && non_empty;
      end
      cde_pkg::CMD_POP_REAR: begin
        ok_next       = non_empty;
        ctrl.pop_rear = accept && non_empty;
      end
      cde_pkg::CMD_QUERY: begin
        ok_next = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
    if (ctrl.push_front || ctrl.push_rear) begin
      cnt_next = cnt + 1'b1;
    end else if (ctrl.pop_front || ctrl.pop_rear) begin
      cnt_next = cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cap_wr) begin
        cnt <= '0;
      end else begin
        cnt <= cnt_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok <= ok_next;
    end
  end

  for (genvar i = 0; i < D; i++) begin : g_slot
    logic [cde_pkg::DATA_W-1:0] l_data;
    logic                       l_valid;
    logic [cde_pkg::DATA_W-1:0] r_data;
    logic                       r_valid;

    if (i == 0) begin : g_head
      assign l_data  = in_ch.value;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_data  = slot_data[i-1];
      assign l_valid = slot_valid[i-1];
    end

    if (i == D - 1) begin : g_end
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_data  = slot_data[i+1];
      assign r_valid = slot_valid[i+1];
    end

    cde_cell u_slot (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (slot_data[i]),
      .valid       (slot_valid[i]),
      .rear_data   (slot_rear[i])
    );
  end

  always_comb begin
    rear_word = '0;
    for (int i = 0; i < D; i++) begin
      rear_word = rear_word | slot_rear[i];
    end
  end

  assign empty              = !non_empty;
  assign out_ch.valid       = out_valid;
  assign out_ch.ok          = ok;
  assign out_ch.is_empty    = empty;
  assign out_ch.is_full     = cnt == eff_cap;
  assign out_ch.count       = cde_pkg::OUT_CNT_W'(cnt);
  assign out_ch.front_value = empty ? '1 : slot_data[0];
  assign out_ch.rear_value  = empty ? '1 : rear_word;

endmodule

>>> design/cde_checker.sv
// Port-level checks for the circular deque engine, bound to the top level.
module cde_checker (
  input logic          clk,
  input logic          rst,
  cde_in_if.sink       in_ch,
  cde_out_if.source    out_ch
);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> out_ch.valid)
    else $error("no result after command transfer");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.is_empty == (out_ch.count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.is_empty |-> (out_ch.front_value == -1) && (out_ch.rear_value == -1))
    else $error("empty deque shows a word");

  a_query_ok: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && (in_ch.command == cde_pkg::CMD_QUERY) |=> out_ch.ok)
    else $error("query refused");

endmodule

bind circular_deque_engine_core cde_checker u_cde_checker (
  .clk    (clk),
  .rst    (rst),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

>>> test/circular_deque_engine_core_tb.sv
// Testbench for circular_deque_engine_core: directed and random commands against a predictor.
module circular_deque_engine_core_tb;
  import cde_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_LEN    = 80;
  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] ADDR_UNUSED   = ADDR_W'(4);

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic [OUT_CNT_W-1:0]     count;
  } deque_status_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  cde_in_if  in_ch ();
  cde_out_if out_ch ();

  circular_deque_engine_core dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic signed [DATA_W-1:0] ring_words [DEPTH];
  int                       head_pos;
  int                       tail_pos;
  int                       fill;
  logic [CAP_W-1:0]         cap_setting;
  deque_status_t            pending_status [$];
  int                       errors = 0;
  int                       quiet_cycles = 0;
  bit                       idle_on = 1'b0;
  bit                       hold_req = 1'b0;

  always #1 clk = ~clk;

  function automatic int active_capacity();
    if (cap_setting == 0) return 1;
    if (int'(cap_setting) > DEPTH) return DEPTH;
    return int'(cap_setting);
  endfunction

  function automatic void clear_deque();
    head_pos = 0;
    tail_pos = active_capacity() - 1;
    fill     = 0;
  endfunction

  function automatic deque_status_t apply_command(logic [CMD_W-1:0] cmd,
                                                  logic signed [DATA_W-1:0] val);
    deque_status_t s;
    int c;
    c = active_capacity();
    s.ok = 1'b0;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (fill < c) begin
          head_pos = (head_pos + c - 1) % c;
          ring_words[head_pos] = val;
          fill++;
          if (fill == 1) tail_pos = head_pos;
          s.ok = 1'b1;
        end
      end
      CMD_PUSH_REAR: begin
        if (fill < c) begin
          tail_pos = (tail_pos + 1) % c;
          ring_words[tail_pos] = val;
          fill++;
          if (fill == 1) head_pos = tail_pos;
          s.ok = 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (fill > 0) begin
          head_pos = (head_pos + 1) % c;
          fill--;
          s.ok = 1'b1;
        end
      end
      CMD_POP_REAR: begin
        if (fill > 0) begin
          tail_pos = (tail_pos + c - 1) % c;
          fill--;
          s.ok = 1'b1;
        end
      end
      CMD_QUERY: begin
        s.ok = 1'b1;
      end
      default: begin
      end
    endcase
    s.front_value = (fill == 0) ? -1 : ring_words[head_pos];
    s.rear_value  = (fill == 0) ? -1 : ring_words[tail_pos];
    s.is_empty    = (fill == 0);
    s.is_full     = (fill == c);
    s.count       = OUT_CNT_W'(fill);
    return s;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    deque_status_t want;
    if (rst) begin
      cap_setting = CAP_RESET;
      clear_deque();
      pending_status.delete();
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (psel && penable && pwrite && pready) begin
        quiet_cycles = 0;
        if ((paddr >> 2) == ADDR_W'(REG_CAPACITY)) begin
          cap_setting = pwdata[CAP_W-1:0];
          clear_deque();
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        quiet_cycles = 0;
        pending_status.push_back(apply_command(in_ch.command, in_ch.value));
      end
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        if (pending_status.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = pending_status.pop_front();
          check_field("ok", DATA_W'(want.ok), DATA_W'(out_ch.ok));
          check_field("front_value", want.front_value, out_ch.front_value);
          check_field("rear_value", want.rear_value, out_ch.rear_value);
          check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(out_ch.is_empty));
          check_field("is_full", DATA_W'(want.is_full), DATA_W'(out_ch.is_full));
          check_field("count", DATA_W'(want.count), DATA_W'(out_ch.count));
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result-side stalls: random bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_command(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] val);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_ch.valid   <= 1'b0;
      in_ch.command <= CMD_W'($urandom());
      in_ch.value   <= $urandom();
      repeat ($urandom_range(1, 15) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value   <= val;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending_status.size() == 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    write_reg(ADDR_CAPACITY, ($urandom() & ~32'(2 ** CAP_W - 1)) | 32'(cap));
  endtask

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -1;
      3: return 0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return CMD_W'($urandom_range(int'(CMD_QUERY) + 1, 2 ** CMD_W - 1));
    if (r < 8) return CMD_QUERY;
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
    end
    return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
  endfunction

  task automatic test_directed();
    drain();
    send_command(CMD_QUERY, 32'sh12345678);
    send_command(CMD_POP_FRONT, -1);
    send_command(CMD_POP_REAR, 0);
    send_command(CMD_PUSH_FRONT, 32'sh7fffffff);
    send_command(CMD_PUSH_REAR, 32'sh80000000);
    send_command(CMD_PUSH_FRONT, -1);
    send_command(CMD_PUSH_REAR, 0);
    send_command(CMD_QUERY, 32'sh5a5a5a5a);
    send_command(CMD_POP_FRONT, 32'sh0f0f0f0f);
    send_command(CMD_POP_REAR, 32'sh7fffffff);
    for (int k = int'(CMD_QUERY) + 1; k < 2 ** CMD_W; k++) begin
      send_command(CMD_W'(k), pick_word());
    end
    send_command(CMD_POP_FRONT, 0);
    send_command(CMD_POP_REAR, 0);
    drain();
    set_capacity(CAP_W'(2));
    send_command(CMD_PUSH_REAR, 32'sh00000001);
    send_command(CMD_PUSH_FRONT, 32'sh00000002);
    send_command(CMD_PUSH_REAR, 32'sh00000003);
    send_command(CMD_POP_REAR, 0);
    send_command(CMD_POP_FRONT, 0);
    send_command(CMD_POP_FRONT, 0);
    drain();
    // zero capacity behaves as a single entry
    set_capacity(CAP_W'(0));
    send_command(CMD_PUSH_FRONT, 32'shcafe0001);
    send_command(CMD_PUSH_REAR, 32'shcafe0002);
    send_command(CMD_QUERY, 0);
    drain();
  endtask

  task automatic test_unmapped_write();
    write_reg(ADDR_UNUSED, 32'(2));
    send_command(CMD_QUERY, 0);
    send_command(CMD_PUSH_REAR, pick_word());
    drain();
  endtask

  task automatic test_backpressure();
    set_capacity(CAP_W'(16));
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_command(pick_command(75), pick_word());
    end
    drain();
  endtask

  task automatic test_random(logic [CAP_W-1:0] cap, int n);
    int period;
    int push_pct;
    set_capacity(cap);
    period = 3 * active_capacity() + 4;
    for (int i = 0; i < n; i++) begin
      push_pct = ((i / period) % 2 == 0) ? 80 : 25;
      send_command(pick_command(push_pct), pick_word());
    end
    drain();
  endtask

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.command = '0;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    test_directed();
    test_unmapped_write();
    test_backpressure();
    test_random(CAP_W'(1), 120);
    test_random(CAP_W'(2), 120);
    test_random(CAP_W'(3), 120);
    test_random(CAP_W'(16), 120);
    test_random(CAP_W'(0), 120);
    test_random(CAP_W'(5), 120);
    test_random(CAP_W'(31), 120);
    test_random(CAP_W'(17), 120);
    test_random(CAP_W'(7), 120);
    test_random(CAP_W'($urandom_range(1, DEPTH)), 120);
    test_random(CAP_W'(4), 120);
    idle_on = 1'b0;
    test_random(CAP_W'(16), 80);
    test_random(CAP_W'(6), 70);

    repeat (10) @(posedge clk);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
